// ===== src/itc_pkg.sv =====
package itc_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int MASK_W      = NUM_CLASSES;
	localparam int CLASS_W     = $clog2(NUM_CLASSES);
	localparam int STAMP_W     = 32;
	localparam int TALLY_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [2:0] {
		PH_WAIT_PRE  = 3'd0,
		PH_CONF_PRE  = 3'd1,
		PH_WAIT_POST = 3'd2,
		PH_CONF_POST = 3'd3,
		PH_CONFIRMED = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRE_MASK  = 3'd0,
		REG_POST_MASK = 3'd1,
		REG_PRE_DUR   = 3'd2,
		REG_PRE_MIN   = 3'd3,
		REG_POST_DUR  = 3'd4,
		REG_POST_MIN  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [MASK_W-1:0]  pre_class_mask;
		logic [MASK_W-1:0]  post_class_mask;
		logic [STAMP_W-1:0] pre_duration_ms;
		logic [TALLY_W-1:0] pre_min_events;
		logic [STAMP_W-1:0] post_duration_ms;
		logic [TALLY_W-1:0] post_min_events;
	} cfg_t;

	// Empty mask accepts every class.
	function automatic logic class_ok(input logic [MASK_W-1:0] mask,
			input logic [CLASS_W-1:0] cls);
		return (mask == '0) || mask[cls];
	endfunction

	// A stamp before the start never counts as passed.
	function automatic logic time_passed(input logic [STAMP_W-1:0] now,
			input logic [STAMP_W-1:0] start, input logic [STAMP_W-1:0] dur);
		logic [STAMP_W:0] diff;
		diff = {1'b0, now} - {1'b0, start};
		return !diff[STAMP_W] && (diff[STAMP_W-1:0] > dur);
	endfunction

endpackage

// ===== src/itc_cfg_regs.sv =====
module itc_cfg_regs
	import itc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PRE_MASK:  cfg_q.pre_class_mask   <= cfg_data[MASK_W-1:0];
				REG_POST_MASK: cfg_q.post_class_mask  <= cfg_data[MASK_W-1:0];
				REG_PRE_DUR:   cfg_q.pre_duration_ms  <= cfg_data[STAMP_W-1:0];
				REG_PRE_MIN:   cfg_q.pre_min_events   <= cfg_data[TALLY_W-1:0];
				REG_POST_DUR:  cfg_q.post_duration_ms <= cfg_data[STAMP_W-1:0];
				REG_POST_MIN:  cfg_q.post_min_events  <= cfg_data[TALLY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/itc_tracker.sv =====
module itc_tracker
	import itc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [STAMP_W-1:0] stamp,
	input  logic [CLASS_W-1:0] cls,
	input  cfg_t               cfg,
	output phase_t             phase_next
);

	phase_t             phase_q, phase_d;
	logic [STAMP_W-1:0] start_q, start_d;
	logic [TALLY_W-1:0] tally_q, tally_d, tally_inc;
	logic               pre_ok, post_ok, pre_done, post_passed, post_done;

	always_comb begin
		pre_ok      = class_ok(cfg.pre_class_mask, cls);
		post_ok     = class_ok(cfg.post_class_mask, cls);
		tally_inc   = (tally_q == '1) ? tally_q : tally_q + 1'b1;
		pre_done    = time_passed(stamp, start_q, cfg.pre_duration_ms)
			&& (tally_inc >= cfg.pre_min_events);
		post_passed = time_passed(stamp, start_q, cfg.post_duration_ms);
		post_done   = post_passed && (tally_inc >= cfg.post_min_events);
	end

	// Entering a confirm phase always restarts the clock, so it can never
	// finish in the same step: a fall-through stops there.
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		tally_d = tally_q;
		case (phase_q)
			PH_WAIT_PRE: begin
				if (pre_ok) begin
					phase_d = PH_CONF_PRE;
					start_d = stamp;
					tally_d = TALLY_W'(1);
				end else begin
					phase_d = PH_WAIT_PRE;
					tally_d = '0;
				end
			end
			PH_CONF_PRE: begin
				if (!pre_ok || (pre_done && !post_ok)) begin
					phase_d = PH_WAIT_PRE;
					tally_d = '0;
				end else if (pre_done) begin
					phase_d = PH_CONF_POST;
					start_d = stamp;
					tally_d = TALLY_W'(1);
				end else begin
					tally_d = tally_inc;
				end
			end
			PH_WAIT_POST: begin
				if (post_ok) begin
					phase_d = PH_CONF_POST;
					start_d = stamp;
					tally_d = TALLY_W'(1);
				end else begin
					phase_d = PH_WAIT_PRE;
					tally_d = '0;
				end
			end
			PH_CONF_POST: begin
				if (!post_ok) begin
					phase_d = PH_WAIT_PRE;
					tally_d = '0;
				end else if (post_done) begin
					phase_d = PH_CONFIRMED;
					start_d = stamp;
					tally_d = tally_inc;
				end else begin
					tally_d = tally_inc;
				end
			end
			PH_CONFIRMED: begin
				if (!post_ok || post_passed) begin
					phase_d = PH_WAIT_PRE;
					tally_d = '0;
				end
			end
			default: begin
				phase_d = PH_WAIT_PRE;
				tally_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_PRE;
			start_q <= '0;
			tally_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			start_q <= start_d;
			tally_q <= tally_d;
		end
	end

	assign phase_next = phase_d;

endmodule

// ===== src/illumination_transition_confirmer_core.sv =====
// Illumination transition confirmer. Each request on the s_ side carries one
// observation (s_tdata[31:0] stamp in ms, s_tdata[33:32] class code) and
// yields exactly one result on the m_ side (m_tdata[0] detected, m_tdata[3:1]
// phase after the step: 0 wait pre, 1 confirm pre, 2 wait post, 3 confirm
// post, 4 confirmed). Throughput is one request per clock while the output is
// not stalled; a request passes from the input register to the result register.
// The rate is set by the phase/start/tally update: every observation reads the
// state left by the one before, and that update closes between those two registers.
// The result register decouples the two sides, so one new request can enter the
// input register while a finished result waits. Configuration goes through
// cfg_we/cfg_index/cfg_data (index 0 pre mask, 1 post mask, 2 pre duration, 3
// pre minimum events, 4 post duration, 5 post minimum events; other indexes are
// ignored) and may be written only while no request is in flight. Valid flags,
// configuration and tracker state reset to zero; data registers do not.
module illumination_transition_confirmer_core
	import itc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,   // stamp_ms[31:0], light_class[33:32], zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // detected[0], phase_now[3:1], zero
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg;
	logic               valid_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [CLASS_W-1:0] class_s1;
	logic               out_valid_q;
	phase_t             phase_out_q;
	phase_t             phase_next;
	logic               out_free, step;

	itc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the held request into the result register whenever that
	// register is empty or being drained this cycle.
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register: capture a request, drop it once it has stepped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			stamp_s1 <= s_tdata[STAMP_W-1:0];
			class_s1 <= s_tdata[STAMP_W +: CLASS_W];
		end
	end

	itc_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.stamp      (stamp_s1),
		.cls        (class_s1),
		.cfg        (cfg),
		.phase_next (phase_next)
	);

	// Result register: hold while stalled, load the new phase on a step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			phase_out_q <= phase_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, phase_out_q, (phase_out_q == PH_CONFIRMED)};

endmodule

// ===== src/itc_checker.sv =====
module itc_checker
	import itc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [7:0]            m_tdata
);

	// Stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Detected flag agrees with the confirmed phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == PH_CONFIRMED)))
		else $error("detected disagrees with phase");

	// Phase stays within the five defined phases, padding stays zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] <= PH_CONFIRMED) && (m_tdata[7:4] == '0))
		else $error("malformed result");

	// An idle pipeline with a free output always takes a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
		else $error("input stalled while pipeline empty");

endmodule

bind illumination_transition_confirmer_core itc_checker u_itc_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
	import itc_pkg::*;

	localparam int unsigned RUN_LIMIT    = 150000;
	localparam int          RANDOM_SETS  = 10;
	localparam int          SET_ITEMS    = 53;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic   detected;
		phase_t phase_now;
	} outcome_t;

	// Tracks the transition state as the block should see it and keeps the
	// outcomes still owed on the result side.
	class transition_tracker;
		cfg_t               regs;
		phase_t             phase;
		logic [STAMP_W-1:0] start_ms;
		logic [TALLY_W-1:0] tally;
		outcome_t           outcomes_q[$];
		int                 mismatches;
		int                 checked;

		function new();
			regs       = '0;
			phase      = PH_WAIT_PRE;
			start_ms   = '0;
			tally      = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_PRE_MASK:  regs.pre_class_mask   = val[MASK_W-1:0];
				REG_POST_MASK: regs.post_class_mask  = val[MASK_W-1:0];
				REG_PRE_DUR:   regs.pre_duration_ms  = val[STAMP_W-1:0];
				REG_PRE_MIN:   regs.pre_min_events   = val[TALLY_W-1:0];
				REG_POST_DUR:  regs.post_duration_ms = val[STAMP_W-1:0];
				REG_POST_MIN:  regs.post_min_events  = val[TALLY_W-1:0];
				default: ;
			endcase
		endfunction

		function bit accepts(logic [MASK_W-1:0] mask, logic [CLASS_W-1:0] cls);
			if (mask == '0)
				return 1'b1;
			return mask[cls];
		endfunction

		// A stamp before the start never counts as elapsed.
		function bit outlasted(logic [STAMP_W-1:0] now, logic [STAMP_W-1:0] dur);
			logic [STAMP_W-1:0] span;
			if (now < start_ms)
				return 1'b0;
			span = now - start_ms;
			return span > dur;
		endfunction

		function void fall_back();
			phase = PH_WAIT_PRE;
			tally = '0;
		endfunction

		function void count_event();
			if (tally != '1)
				tally = tally + 1'b1;
		endfunction

		// Advance the phase machine by one observation, falling through as
		// far as the conditions allow, and queue the outcome.
		function void note_observation(logic [STAMP_W-1:0] now, logic [CLASS_W-1:0] cls);
			bit       pre_ok;
			bit       post_ok;
			bit       settled;
			outcome_t owed;
			pre_ok  = accepts(regs.pre_class_mask, cls);
			post_ok = accepts(regs.post_class_mask, cls);
			settled = 1'b0;
			if (phase == PH_WAIT_PRE) begin
				if (!pre_ok) begin
					fall_back();
					settled = 1'b1;
				end else begin
					phase    = PH_CONF_PRE;
					start_ms = now;
					tally    = '0;
				end
			end
			if (!settled && phase == PH_CONF_PRE) begin
				if (!pre_ok) begin
					fall_back();
					settled = 1'b1;
				end else begin
					count_event();
					if (!outlasted(now, regs.pre_duration_ms) || tally < regs.pre_min_events)
						settled = 1'b1;
					else
						phase = PH_WAIT_POST;
				end
			end
			if (!settled && phase == PH_WAIT_POST) begin
				if (!post_ok) begin
					fall_back();
					settled = 1'b1;
				end else begin
					phase    = PH_CONF_POST;
					start_ms = now;
					tally    = '0;
				end
			end
			if (!settled && phase == PH_CONF_POST) begin
				if (!post_ok) begin
					fall_back();
					settled = 1'b1;
				end else begin
					count_event();
					if (!outlasted(now, regs.post_duration_ms) || tally < regs.post_min_events) begin
						settled = 1'b1;
					end else begin
						phase    = PH_CONFIRMED;
						start_ms = now;
					end
				end
			end
			// Confirmed lives until the post duration runs out or a stray class shows up.
			if (!settled && (!post_ok || outlasted(now, regs.post_duration_ms)))
				fall_back();
			owed.detected  = (phase == PH_CONFIRMED);
			owed.phase_now = phase;
			outcomes_q.insert(outcomes_q.size(), owed);
		endfunction

		function void check_outcome(logic [7:0] data);
			outcome_t want;
			if (outcomes_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: detected=%0b phase=%0d", data[0], data[3:1]);
				return;
			end
			want = outcomes_q.pop_front();
			checked++;
			if (data[0] !== want.detected || data[3:1] !== want.phase_now) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected detected=%0b phase=%0d, got detected=%0b phase=%0d",
						checked, want.detected, want.phase_now, data[0], data[3:1]);
			end
		endfunction

		function int pending();
			return outcomes_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [39:0]           s_tdata;   // stamp_ms[31:0], light_class[33:32], zero
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;   // detected[0], phase_now[3:1], zero
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	transition_tracker tr;
	int unsigned       cycle_count      = 0;
	int                long_hold_cycles = 0;
	bit                quiet            = 1'b0;
	int                settings_loaded  = 0;

	illumination_transition_confirmer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tr.check_outcome(m_tdata);
	end

	// Result side: random stall bursts in lively stretches, a long hold when
	// asked for, and none once the run goes quiet.
	initial begin : result_sink
		bit lively;
		lively = 1'b1;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				lively = !lively;
			if (long_hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
				m_tready <= 1'b1;
			end else if (!quiet && lively && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one observation and hold it until the block takes the request.
	task automatic push_obs(input logic [STAMP_W-1:0] stamp, input logic [CLASS_W-1:0] cls);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, cls, stamp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tr.note_observation(stamp, cls);
	endtask

	task automatic idle_gap(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending and let every owed result come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tr.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tr.write_reg(idx, val);
	endtask

	// Write all six registers, junk above the narrow fields, and the two
	// unused indexes, which must change nothing.
	task automatic load_settings(input cfg_t s);
		logic [CFG_DATA_W-1:0] junk;
		junk = $urandom;
		write_reg(REG_PRE_MASK,  {junk[CFG_DATA_W-1:MASK_W], s.pre_class_mask});
		write_reg(REG_POST_MASK, {junk[CFG_DATA_W-1:MASK_W], s.post_class_mask});
		write_reg(REG_PRE_DUR,   s.pre_duration_ms);
		write_reg(REG_PRE_MIN,   {junk[CFG_DATA_W-1:TALLY_W], s.pre_min_events});
		write_reg(REG_POST_DUR,  s.post_duration_ms);
		write_reg(REG_POST_MIN,  {junk[CFG_DATA_W-1:TALLY_W], s.post_min_events});
		write_reg(REG_SPARE_LO,  $urandom);
		write_reg(REG_SPARE_HI,  $urandom);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	function automatic logic [STAMP_W-1:0] pick_duration();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic logic [TALLY_W-1:0] pick_min_events();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return TALLY_W'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic cfg_t make_setting();
		cfg_t s;
		s.pre_class_mask   = MASK_W'($urandom_range(0, 2**MASK_W - 1));
		s.post_class_mask  = MASK_W'($urandom_range(0, 2**MASK_W - 1));
		s.pre_duration_ms  = pick_duration();
		s.pre_min_events   = pick_min_events();
		s.post_duration_ms = pick_duration();
		s.post_min_events  = pick_min_events();
		return s;
	endfunction

	// Random class out of a set; an empty set takes any class.
	function automatic logic [CLASS_W-1:0] pick_class(input logic [MASK_W-1:0] mask);
		logic [CLASS_W-1:0] c;
		c = CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
		if (mask == '0)
			return c;
		while (!mask[c])
			c = c + 1'b1;
		return c;
	endfunction

	// Mostly well-formed runs: rising stamps and classes that suit the phase
	// the block is in; the rest stray classes and stamps out of order.
	task automatic run_random_phase(input int n_items, input bit lively_src);
		logic [STAMP_W-1:0] t;
		logic [MASK_W-1:0]  pre;
		logic [MASK_W-1:0]  post;
		logic [MASK_W-1:0]  bridge;
		int                 step_max;
		int                 r;
		bit                 lively;
		case ($urandom_range(0, 3))
			0: t = $urandom_range(0, 1000);
			1: t = 32'hFFFF_FFFF - $urandom_range(0, 300);
			default: t = $urandom;
		endcase
		step_max = $urandom_range(1, 16);
		lively   = lively_src;
		pre      = tr.regs.pre_class_mask;
		post     = tr.regs.post_class_mask;
		// The item that closes confirm pre must also fit the post set.
		if (pre == '0)
			bridge = post;
		else if (post == '0)
			bridge = pre;
		else
			bridge = ((pre & post) != '0) ? (pre & post) : pre;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				t = t + $urandom_range(0, step_max);
				if (tr.phase == PH_WAIT_PRE || tr.phase == PH_CONF_PRE)
					push_obs(t, ($urandom_range(0, 2) == 0) ? pick_class(bridge) : pick_class(pre));
				else
					push_obs(t, pick_class(post));
			end else if (r < 90) begin
				t = t + $urandom_range(0, step_max);
				push_obs(t, CLASS_W'($urandom_range(0, NUM_CLASSES - 1)));
			end else if (r < 95) begin
				push_obs(t - $urandom_range(1, 50), CLASS_W'($urandom_range(0, NUM_CLASSES - 1)));
			end else begin
				push_obs($urandom, CLASS_W'($urandom_range(0, NUM_CLASSES - 1)));
			end
			if (lively_src && $urandom_range(0, 31) == 0)
				lively = !lively;
			if (lively && $urandom_range(0, 5) == 0)
				idle_gap($urandom_range(1, 14));
		end
	endtask

	initial begin : stimulus
		cfg_t s;
		tr = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every set empty, zero durations, no minimum. Walk through
		// every phase but wait post, then start at the top stamp and go back in time.
		push_obs(32'd0, 2'd0);
		push_obs(32'd1, 2'd1);
		push_obs(32'd2, 2'd2);
		push_obs(32'd3, 2'd3);
		push_obs(32'hFFFF_FFFF, 2'd0);
		push_obs(32'd5, 2'd1);
		push_obs(32'hFFFF_FFFF, 2'd2);
		drain_results();

		// Overlapping sets, the longest post duration and the highest post
		// minimum: stray classes, a closing item outside the post set, and
		// a post phase that cannot end.
		s.pre_class_mask   = 4'b0011;
		s.post_class_mask  = 4'b0110;
		s.pre_duration_ms  = 32'd10;
		s.pre_min_events   = 16'd2;
		s.post_duration_ms = '1;
		s.post_min_events  = '1;
		load_settings(s);
		push_obs(32'd50, 2'd3);
		push_obs(32'd100, 2'd0);
		push_obs(32'd111, 2'd0);
		push_obs(32'd120, 2'd0);
		push_obs(32'd131, 2'd1);
		push_obs(32'd140, 2'd2);
		push_obs(32'd150, 2'd0);
		drain_results();

		// Full pre set, empty post set, all zero: confirmed and its lifetime,
		// then a stamp that wraps past the top.
		s.pre_class_mask   = '1;
		s.post_class_mask  = '0;
		s.pre_duration_ms  = '0;
		s.pre_min_events   = '0;
		s.post_duration_ms = '0;
		s.post_min_events  = '0;
		load_settings(s);
		push_obs(32'd1000, 2'd2);
		push_obs(32'd1001, 2'd3);
		push_obs(32'd1002, 2'd1);
		push_obs(32'd1002, 2'd0);
		push_obs(32'd1003, 2'd2);
		push_obs(32'hFFFF_FFF0, 2'd1);
		push_obs(32'hFFFF_FFFF, 2'd3);
		push_obs(32'd5, 2'd0);
		drain_results();

		for (int set = 0; set < RANDOM_SETS; set++) begin
			load_settings(make_setting());
			// Once, hold off the result side while requests keep coming.
			if (set == 1)
				long_hold_cycles = 300;
			quiet = (set >= RANDOM_SETS - 2);
			run_random_phase(SET_ITEMS, !quiet && $urandom_range(0, 3) != 0);
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("checked %0d results over %0d register settings", tr.checked, settings_loaded);
		$display("phases walked with fall-through, stray classes, stamp wrap and long stalls");
		if (tr.mismatches == 0 && tr.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", tr.mismatches, tr.pending());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
